@@ hdl/pilc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pilc_pkg: shared types and constants
// Opcodes, register indexes, field widths and priority encoders for the
// sixteen-level priority interrupt control block.
// ----------------------------------------------------------------------------
package pilc_pkg;

   localparam int LEVEL_W    = 4;
   localparam int LEVELS     = 16;
   localparam int SOURCES    = 11;
   localparam int CSR_DATA_W = 16;

   // opcodes
   localparam logic [1:0] OP_RAISE  = 2'd0;
   localparam logic [1:0] OP_DEVICE = 2'd1;
   localparam logic [1:0] OP_CHECK  = 2'd2;

   // register indexes
   localparam logic CSR_LEVEL_ENABLE    = 1'b0;
   localparam logic CSR_INTERNAL_ENABLE = 1'b1;

   localparam logic [LEVELS-1:0]  DEVICE_MASK    = 16'hBC00;
   localparam logic [LEVEL_W-1:0] INTERNAL_LEVEL = 4'd14;
   localparam int                 Z_SOURCE       = 5;
   localparam logic [SOURCES-1:0] TRAP_SOURCES   = 11'h01C;

   typedef struct packed {
      logic [1:0]         opcode;
      logic [LEVEL_W-1:0] level;
      logic [SOURCES-1:0] source_mask;
      logic [LEVELS-1:0]  device_lines;
      logic               error_flag;
      logic               interrupts_on;
   } item_type;

   typedef struct packed {
      logic [LEVEL_W-1:0] current_level;
      logic               switched;
      logic               trap;
      logic [3:0]         internal_code;
      logic [LEVELS-1:0]  pending_levels;
   } result_type;

   // highest set bit, 0 when none
   function automatic logic [LEVEL_W-1:0] top_level(input logic [LEVELS-1:0] v);
      logic [LEVEL_W-1:0] r;
      r = '0;
      for (int i = 0; i < LEVELS; i++) begin
         if (v[i]) r = LEVEL_W'(i);
      end
      return r;
   endfunction

   function automatic logic [3:0] top_source(input logic [SOURCES-1:0] v);
      logic [3:0] r;
      r = '0;
      for (int i = 0; i < SOURCES; i++) begin
         if (v[i]) r = 4'(i);
      end
      return r;
   endfunction

endpackage
`default_nettype wire

@@ hdl/pilc_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pilc_core: interrupt state and per-item update
// Holds pending levels, internal sources, internal code, running level and
// recheck flag; computes the next state and the result of one item.
// ----------------------------------------------------------------------------
module pilc_core (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                fire,
   input  wire pilc_pkg::item_type                  item,
   input  wire logic [pilc_pkg::LEVELS-1:0]         level_enable,
   input  wire logic [pilc_pkg::SOURCES-1:0]        internal_enable,
   output pilc_pkg::result_type                     result
);

   logic [pilc_pkg::LEVELS-1:0]  pending_ff, pending_in;
   logic [pilc_pkg::SOURCES-1:0] detected_ff, detected_in;
   logic [3:0]                   code_ff, code_in;
   logic [pilc_pkg::LEVEL_W-1:0] running_ff, running_in;
   logic                         recheck_ff, recheck_in;

   always_comb begin
      logic                         recomp;
      logic                         sw;
      logic                         trp;
      logic [pilc_pkg::SOURCES-1:0] act;
      logic [pilc_pkg::LEVEL_W-1:0] prio;

      pending_in  = pending_ff;
      detected_in = detected_ff;
      code_in     = code_ff;
      running_in  = running_ff;
      recheck_in  = recheck_ff;
      recomp      = 1'b0;
      sw          = 1'b0;
      trp         = 1'b0;
      act         = '0;
      prio        = '0;

      unique case (item.opcode)
         pilc_pkg::OP_RAISE: begin
            if (item.level == pilc_pkg::INTERNAL_LEVEL) begin
               detected_in = detected_ff | item.source_mask;
               if ((detected_in & internal_enable) != '0)
                  pending_in[pilc_pkg::INTERNAL_LEVEL] = 1'b1;
               trp = (item.source_mask & pilc_pkg::TRAP_SOURCES) != '0;
            end else begin
               pending_in[item.level] = 1'b1;
            end
            recomp = 1'b1;
         end
         pilc_pkg::OP_DEVICE: begin
            pending_in = (pending_ff & ~pilc_pkg::DEVICE_MASK)
                       | (item.device_lines & pilc_pkg::DEVICE_MASK);
            if (pending_in != pending_ff) recheck_in = 1'b1;
         end
         pilc_pkg::OP_CHECK: begin
            if (recheck_ff) begin
               recheck_in = 1'b0;
               recomp     = 1'b1;
            end
         end
         default: ;
      endcase

      // internal source recompute
      if (recomp) begin
         if (item.error_flag) detected_in[pilc_pkg::Z_SOURCE] = 1'b1;
         act = detected_in & internal_enable;
         if (act != '0) begin
            pending_in[pilc_pkg::INTERNAL_LEVEL] = 1'b1;
            code_in    = pilc_pkg::top_source(act);
            recheck_in = 1'b1;
         end
      end

      // level switch, sees the pending word after the recompute
      if (item.opcode == pilc_pkg::OP_CHECK && recheck_ff && item.interrupts_on) begin
         prio = pilc_pkg::top_level(level_enable & pending_in);
         if (prio != running_ff) begin
            running_in = prio;
            sw         = 1'b1;
         end
      end

      result.current_level  = running_in;
      result.switched       = sw;
      result.trap           = trp;
      result.internal_code  = code_in;
      result.pending_levels = pending_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff  <= '0;
         detected_ff <= '0;
         code_ff     <= '0;
         running_ff  <= '0;
         recheck_ff  <= 1'b0;
      end else if (fire) begin
         pending_ff  <= pending_in;
         detected_ff <= detected_in;
         code_ff     <= code_in;
         running_ff  <= running_in;
         recheck_ff  <= recheck_in;
      end
   end

endmodule
`default_nettype wire

@@ hdl/priority_interrupt_level_control.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Response: rsp_valid rises once the request has passed the input register and then
// the result register; rsp_stall can hold the item in either register.
// Throughput: one item per cycle while the response channel is not stalled; the
// state update in pilc_core is applied to each item as it fires.
// Synchronous active-high reset clears all interrupt state, both enable
// registers and both valid flags.
// ----------------------------------------------------------------------------
// priority_interrupt_level_control: sixteen-level priority interrupt control
// Input register, state update core, result register and config registers.
// ----------------------------------------------------------------------------
module priority_interrupt_level_control (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   // request channel
   input  wire logic                                 req_valid,
   output logic                                      req_stall,
   input  wire logic [1:0]                           req_opcode,
   input  wire logic [pilc_pkg::LEVEL_W-1:0]         req_level,
   input  wire logic [pilc_pkg::SOURCES-1:0]         req_source_mask,
   input  wire logic [pilc_pkg::LEVELS-1:0]          req_device_lines,
   input  wire logic                                 req_error_flag,
   input  wire logic                                 req_interrupts_on,
   // response channel
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output logic [pilc_pkg::LEVEL_W-1:0]              rsp_current_level,
   output logic                                      rsp_switched,
   output logic                                      rsp_trap,
   output logic [3:0]                                rsp_internal_code,
   output logic [pilc_pkg::LEVELS-1:0]               rsp_pending_levels,
   // config write channel
   input  wire logic                                 csr_valid,
   output logic                                      csr_ready,
   input  wire logic                                 csr_index,
   input  wire logic [pilc_pkg::CSR_DATA_W-1:0]      csr_data
);

   // input stage
   logic                 item_valid_ff;
   pilc_pkg::item_type   item_ff;
   // result stage
   logic                 rsp_valid_ff;
   pilc_pkg::result_type rsp_ff;
   pilc_pkg::result_type result;
   // enables
   logic [pilc_pkg::LEVELS-1:0]  level_enable_ff;
   logic [pilc_pkg::SOURCES-1:0] internal_enable_ff;

   logic advance;   // result register free or being emptied this cycle
   logic fire;      // item in the input stage is processed this cycle

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign fire      = item_valid_ff && advance;
   // input stage takes a new transfer when empty or when its item moves on
   assign req_stall = item_valid_ff && !advance;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         item_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall && req_valid) begin
         item_ff.opcode        <= req_opcode;
         item_ff.level         <= req_level;
         item_ff.source_mask   <= req_source_mask;
         item_ff.device_lines  <= req_device_lines;
         item_ff.error_flag    <= req_error_flag;
         item_ff.interrupts_on <= req_interrupts_on;
      end
   end

   pilc_core u_core (
      .clock           (clock),
      .reset           (reset),
      .fire            (fire),
      .item            (item_ff),
      .level_enable    (level_enable_ff),
      .internal_enable (internal_enable_ff),
      .result          (result)
   );

   // result register; holds while stalled
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= item_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_current_level  = rsp_ff.current_level;
   assign rsp_switched       = rsp_ff.switched;
   assign rsp_trap           = rsp_ff.trap;
   assign rsp_internal_code  = rsp_ff.internal_code;
   assign rsp_pending_levels = rsp_ff.pending_levels;

   // config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         level_enable_ff    <= '0;
         internal_enable_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            pilc_pkg::CSR_LEVEL_ENABLE:    level_enable_ff    <= csr_data;
            pilc_pkg::CSR_INTERNAL_ENABLE:
               internal_enable_ff <= csr_data[pilc_pkg::SOURCES-1:0];
            default: ;
         endcase
      end
   end

endmodule
`default_nettype wire
